### hw/rtl/brpc_pkg.sv
package brpc_pkg;

    localparam logic       OP_WORD     = 1'b0;
    localparam logic       OP_TICK     = 1'b1;
    localparam logic       SEL_TIME    = 1'b0;

    localparam int         CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OBJECT  = 2'd1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd18750;
    localparam logic [15:0] OBJECT_RESET  = 16'h1454;

    // a report carries at most four entries
    localparam logic [2:0]  RPT_MAX = 3'd4;

    typedef struct packed {
        logic        op;
        logic [31:0] rx_word;
    } item_t;

    typedef struct packed {
        logic [2:0]  entry_total;
        logic        has_entry;
        logic [1:0]  point_id;
        logic [10:0] point_time;
        logic [10:0] point_temp;
        logic        last;
    } result_t;

endpackage

### hw/rtl/beacon_reference_point_collector_top.sv
// Beacon reference point collector.
// Item channel (item_valid/item_stall/item): op 0 carries a receiver word,
// op 1 is one timer tick. A transfer happens when valid is high and stall low.
// Object words clear the table and restart the timeout; point words update or
// append a table entry; ticks advance the timeout counter while it runs.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 timeout,
// index 1 object code; cfg_ready is always high.
// Object words and ticks are handled in the idle state. A point word enters
// the search loop, which compares one table slot per step with the shared id
// compare. The tick that ends the timeout starts a report: one result per
// stored entry, up to four (or one empty result), each through the load/send
// sequencer, which holds while result_stall is high.
// item_stall is high while a search or a report is in progress; a stalled
// result holds in the output register until taken.
// Reset clears the table, the counters and the timer, and loads the
// register defaults (timeout 18750, object code 0x1454).
module beacon_reference_point_collector_top #(
    parameter int TABLE_DEPTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  brpc_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output brpc_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [brpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [15:0]                       cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_LOAD   = 2'd2;
    localparam logic [1:0] ST_SEND   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [15:0]       timeout_reg;
    logic [15:0]       object_reg;
    logic              timer_on_reg, timer_on_next;
    logic [15:0]       tick_reg, tick_next;
    logic [CNT_W-1:0]  stored_reg, stored_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [2:0]        total_reg, total_next;
    logic [1:0]        pt_id_reg, pt_id_next;
    logic              pt_sel_reg, pt_sel_next;
    logic [10:0]       pt_val_reg, pt_val_next;
    logic              result_valid_reg, result_valid_next;
    brpc_pkg::result_t result_reg, result_next;

    logic [1:0]        entry_id_reg   [TABLE_DEPTH];
    logic [10:0]       entry_time_reg [TABLE_DEPTH];
    logic [10:0]       entry_temp_reg [TABLE_DEPTH];

    logic              wr_en;
    logic              wr_new;
    logic [IDX_W-1:0]  rd_idx;
    logic              id_match;
    logic [CNT_W-1:0]  idx_inc;
    logic [15:0]       tick_inc;
    logic [15:0]       packet;
    logic [2:0]        rpt_n;

    assign rd_idx   = idx_reg[IDX_W-1:0];
    assign id_match = (entry_id_reg[rd_idx] == pt_id_reg);
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign tick_inc = tick_reg + 16'd1;
    assign packet   = item.rx_word[15:0];
    assign rpt_n    = (stored_reg > CNT_W'(brpc_pkg::RPT_MAX)) ? brpc_pkg::RPT_MAX
                                                              : 3'(stored_reg);

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        state_next        = state_reg;
        timer_on_next     = timer_on_reg;
        tick_next         = tick_reg;
        stored_next       = stored_reg;
        idx_next          = idx_reg;
        total_next        = total_reg;
        pt_id_next        = pt_id_reg;
        pt_sel_next       = pt_sel_reg;
        pt_val_next       = pt_val_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        wr_en             = 1'b0;
        wr_new            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.op == brpc_pkg::OP_WORD)
                    begin
                        if (item.rx_word[31])
                        begin
                            if (packet == object_reg)
                            begin
                                tick_next     = 16'd0;
                                timer_on_next = 1'b1;
                                stored_next   = '0;
                            end
                            else if (packet[15])
                            begin
                                pt_id_next  = packet[14:13];
                                pt_sel_next = packet[12];
                                pt_val_next = packet[11:1];
                                idx_next    = '0;
                                state_next  = ST_SEARCH;
                            end
                        end
                    end
                    else if (timer_on_reg)
                    begin
                        if (tick_inc == timeout_reg)
                        begin
                            timer_on_next = 1'b0;
                            tick_next     = 16'd0;
                            idx_next      = '0;
                            total_next    = rpt_n;
                            state_next    = ST_LOAD;
                        end
                        else
                        begin
                            tick_next = tick_inc;
                        end
                    end
                end
            end

            ST_SEARCH:
            begin
                if (idx_reg == stored_reg)
                begin
                    // miss: append unless the table is full
                    if (stored_reg < CNT_W'(TABLE_DEPTH))
                    begin
                        wr_en       = 1'b1;
                        wr_new      = 1'b1;
                        stored_next = stored_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
                else if (id_match)
                begin
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            ST_LOAD:
            begin
                if (total_reg == 3'd0)
                begin
                    result_next      = '0;
                    result_next.last = 1'b1;
                end
                else
                begin
                    result_next.entry_total = total_reg;
                    result_next.has_entry   = 1'b1;
                    result_next.point_id    = entry_id_reg[rd_idx];
                    result_next.point_time  = entry_time_reg[rd_idx];
                    result_next.point_temp  = entry_temp_reg[rd_idx];
                    result_next.last        = (idx_inc == CNT_W'(total_reg));
                end
                result_valid_next = 1'b1;
                state_next        = ST_SEND;
            end

            ST_SEND:
            begin
                if (!result_stall)
                begin
                    result_valid_next = 1'b0;
                    if (result_reg.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = ST_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            timeout_reg      <= brpc_pkg::TIMEOUT_RESET;
            object_reg       <= brpc_pkg::OBJECT_RESET;
            timer_on_reg     <= 1'b0;
            tick_reg         <= 16'd0;
            stored_reg       <= '0;
            idx_reg          <= '0;
            total_reg        <= 3'd0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                entry_id_reg[i]   <= 2'd0;
                entry_time_reg[i] <= 11'd0;
                entry_temp_reg[i] <= 11'd0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            timer_on_reg     <= timer_on_next;
            tick_reg         <= tick_next;
            stored_reg       <= stored_next;
            idx_reg          <= idx_next;
            total_reg        <= total_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == brpc_pkg::CFG_TIMEOUT)
                begin
                    timeout_reg <= cfg_data;
                end
                else if (cfg_index == brpc_pkg::CFG_OBJECT)
                begin
                    object_reg <= cfg_data;
                end
            end
            if (wr_en)
            begin
                if (wr_new)
                begin
                    entry_id_reg[rd_idx] <= pt_id_reg;
                end
                if (pt_sel_reg == brpc_pkg::SEL_TIME)
                begin
                    entry_time_reg[rd_idx] <= pt_val_reg;
                end
                else
                begin
                    entry_temp_reg[rd_idx] <= pt_val_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pt_id_reg  <= pt_id_next;
        pt_sel_reg <= pt_sel_next;
        pt_val_reg <= pt_val_next;
        result_reg <= result_next;
    end

`ifndef ASSERT_OFF
    a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= CNT_W'(TABLE_DEPTH))
        else $error("table count beyond depth");

    a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg == (state_reg == ST_SEND))
        else $error("result valid outside send state");

    a_timeout_report: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && item_valid && item.op == brpc_pkg::OP_TICK &&
         timer_on_reg && tick_inc == timeout_reg)
        |=> (state_reg == ST_LOAD && !timer_on_reg && tick_reg == 16'd0))
        else $error("timeout did not start report");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && result.last) |=> (state_reg == ST_IDLE))
        else $error("report did not end on last transfer");

    a_search_append: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH && wr_new) |=> (stored_reg == $past(stored_reg) + CNT_W'(1)))
        else $error("append did not grow table");
`endif

endmodule

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 4;
    localparam logic SEL_TEMP = ~brpc_pkg::SEL_TIME;
    // indexes with no register behind them
    localparam logic [brpc_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [brpc_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int RANDOM_ITEMS = 100;
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 4;
    localparam int HOLD_CYCLES = 150;
    localparam int STUCK_LIMIT = 2000;

    class beacon_table_model;
        logic [15:0] timeout_ticks;
        logic [15:0] object_code;
        bit          timer_on;
        logic [15:0] tick_count;
        int unsigned stored_count;
        logic [1:0]  ids [TABLE_DEPTH];
        logic [10:0] times [TABLE_DEPTH];
        logic [10:0] temps [TABLE_DEPTH];
        brpc_pkg::result_t report_q [$];
        int unsigned errors;
        int unsigned items_taken;
        int unsigned reports;
        int unsigned empty_reports;
        int unsigned results_checked;

        function new();
            timeout_ticks = brpc_pkg::TIMEOUT_RESET;
            object_code = brpc_pkg::OBJECT_RESET;
            timer_on = 1'b0;
            tick_count = '0;
            stored_count = 0;
            foreach (ids[i])
            begin
                ids[i] = '0;
                times[i] = '0;
                temps[i] = '0;
            end
        endfunction

        function void write_reg(logic [brpc_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] val);
            case (idx)
                brpc_pkg::CFG_TIMEOUT: timeout_ticks = val;
                brpc_pkg::CFG_OBJECT:  object_code = val;
                default: ;
            endcase
        endfunction

        function string show(brpc_pkg::result_t r);
            return $sformatf("total=%0d has=%0d id=%0d time=%0d temp=%0d last=%0d",
                             r.entry_total, r.has_entry, r.point_id, r.point_time,
                             r.point_temp, r.last);
        endfunction

        function void note_error(string msg);
            if (errors < 10)
                $display("[%0t] ERROR: %s", $time, msg);
            errors++;
        endfunction

        function void take_item(brpc_pkg::item_t it);
            logic [15:0] packet;
            logic [1:0]  id;
            logic        sel;
            logic [10:0] val;
            int unsigned slot;
            int unsigned n;
            brpc_pkg::result_t r;
            items_taken++;
            if (it.op == brpc_pkg::OP_TICK)
            begin
                if (!timer_on)
                    return;
                tick_count = tick_count + 16'd1;
                if (tick_count != timeout_ticks)
                    return;
                timer_on = 1'b0;
                tick_count = '0;
                reports++;
                n = stored_count;
                if (n > TABLE_DEPTH)
                    n = TABLE_DEPTH;
                if (n > brpc_pkg::RPT_MAX)
                    n = brpc_pkg::RPT_MAX;
                if (n == 0)
                begin
                    r = '0;
                    r.last = 1'b1;
                    report_q.push_back(r);
                    empty_reports++;
                end
                for (int k = 0; k < n; k++)
                begin
                    r.entry_total = 3'(n);
                    r.has_entry = 1'b1;
                    r.point_id = ids[k];
                    r.point_time = times[k];
                    r.point_temp = temps[k];
                    r.last = (k + 1 == n);
                    report_q.push_back(r);
                end
                return;
            end
            if (!it.rx_word[31])
                return;
            packet = it.rx_word[15:0];
            if (packet == object_code)
            begin
                tick_count = '0;
                timer_on = 1'b1;
                stored_count = 0;
                return;
            end
            if (!packet[15])
                return;
            id = packet[14:13];
            sel = packet[12];
            val = packet[11:1];
            slot = stored_count;
            for (int k = 0; k < stored_count && k < TABLE_DEPTH; k++)
                if (slot == stored_count && ids[k] == id)
                    slot = k;
            if (slot == stored_count)
            begin
                if (stored_count >= TABLE_DEPTH)
                    return;
                ids[slot] = id;
                stored_count++;
            end
            // the field not written keeps what the slot held before
            if (sel == brpc_pkg::SEL_TIME)
                times[slot] = val;
            else
                temps[slot] = val;
        endfunction

        function void check_result(brpc_pkg::result_t got);
            brpc_pkg::result_t want;
            if (report_q.size() == 0)
            begin
                note_error({"result with nothing expected: ", show(got)});
                return;
            end
            want = report_q.pop_front();
            results_checked++;
            if (got.entry_total !== want.entry_total || got.has_entry !== want.has_entry ||
                got.point_id !== want.point_id || got.point_time !== want.point_time ||
                got.point_temp !== want.point_temp || got.last !== want.last)
                note_error({"expected ", show(want), " got ", show(got)});
        endfunction

        function void close_out();
            while (report_q.size() != 0)
                note_error({"never received: ", show(report_q.pop_front())});
        endfunction
    endclass

    logic    clk;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    brpc_pkg::item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    brpc_pkg::result_t result;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic [brpc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    beacon_table_model sb;
    int unsigned send_idle_pct = 34;
    int unsigned recv_idle_pct = 73;
    int unsigned items_used = 0;
    int unsigned stuck_cycles = 0;
    logic        holding = 1'b0;
    event        hold_go;

    beacon_reference_point_collector_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // result side: check every transfer, then pick next cycle's stall
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
        result_stall <= holding || ($urandom_range(99) < recv_idle_pct);
    end

    // long receiver hold-off, counted here so the sender keeps going
    always
    begin
        @(hold_go);
        @(posedge clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", STUCK_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    function automatic brpc_pkg::item_t word_item(input logic top, input logic [15:0] packet);
        brpc_pkg::item_t it;
        it.op = brpc_pkg::OP_WORD;
        it.rx_word = $urandom;
        it.rx_word[31] = top;
        it.rx_word[15:0] = packet;
        return it;
    endfunction

    function automatic brpc_pkg::item_t point_item(input logic [1:0] id, input logic sel,
                                                   input logic [10:0] val);
        logic lsb;
        lsb = 1'($urandom_range(1));
        return word_item(1'b1, {1'b1, id, sel, val, lsb});
    endfunction

    function automatic brpc_pkg::item_t random_point();
        return point_item(2'($urandom_range(3)), 1'($urandom_range(1)),
                          11'($urandom_range(2047)));
    endfunction

    function automatic brpc_pkg::item_t tick_item();
        brpc_pkg::item_t it;
        it.op = brpc_pkg::OP_TICK;
        it.rx_word = $urandom;
        return it;
    endfunction

    // a word the block drops: no valid flag, or neither object nor point
    function automatic brpc_pkg::item_t noise_item();
        logic [15:0] packet;
        packet = 16'($urandom);
        if ($urandom_range(1))
            return word_item(1'b0, packet);
        packet[15] = 1'b0;
        if (packet == sb.object_code)
            packet[0] = ~packet[0];
        return word_item(1'b1, packet);
    endfunction

    task automatic send_item(input brpc_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_used++;
        sb.take_item(it);
    endtask

    // wait until every expected result is out and the block has settled
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.report_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [brpc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic cfg_close();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reconfigure();
        drain();
        cfg_write(brpc_pkg::CFG_TIMEOUT, 16'($urandom_range(1, 6)));
        cfg_write(brpc_pkg::CFG_OBJECT,
                  $urandom_range(1) ? brpc_pkg::OBJECT_RESET : 16'($urandom));
        cfg_close();
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(2))
                0: send_item(sb.timer_on ? noise_item() : tick_item());
                1: send_item(noise_item());
                default: send_item(random_point());
            endcase
        end
    endtask

    // object announcement, some points, then mostly ticks mixed with other items until the report fires
    task automatic packet_run(input bit squeeze);
        int unsigned pick;
        send_item(word_item(1'b1, sb.object_code));
        if (squeeze)
            -> hold_go;
        repeat (squeeze ? 6 : $urandom_range(0, 6))
            send_item(random_point());
        while (sb.timer_on)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                send_item(tick_item());
            else if (pick < 85)
                send_item(random_point());
            else if (pick < 90)
                send_item(word_item(1'b1, sb.object_code));
            else
                send_item(noise_item());
        end
    endtask

    initial
    begin
        int unsigned pick;
        bit squeeze;
        bit squeezed;
        squeezed = 1'b0;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset object code, empty report, stale fields, ignored items
        cfg_write(brpc_pkg::CFG_TIMEOUT, 16'd3);
        cfg_write(CFG_SPARE_A, 16'hFFFF);
        cfg_write(CFG_SPARE_B, 16'h0000);
        cfg_close();
        send_item(tick_item());
        send_item(word_item(1'b0, brpc_pkg::OBJECT_RESET));
        send_item(word_item(1'b1, brpc_pkg::OBJECT_RESET));
        repeat (3) send_item(tick_item());
        send_item(point_item(2'd2, brpc_pkg::SEL_TIME, 11'd2047));
        send_item(point_item(2'd2, SEL_TEMP, 11'd0));
        send_item(point_item(2'd0, SEL_TEMP, 11'd2047));
        send_item(point_item(2'd1, brpc_pkg::SEL_TIME, 11'd0));
        send_item(point_item(2'd3, SEL_TEMP, 11'd1));
        send_item(word_item(1'b1, 16'h0123));
        send_item(tick_item());
        send_item(word_item(1'b1, brpc_pkg::OBJECT_RESET));
        send_item(point_item(2'd3, brpc_pkg::SEL_TIME, 11'd9));
        send_item(point_item(2'd1, SEL_TEMP, 11'd100));
        repeat (3) send_item(tick_item());
        send_item(point_item(2'd0, brpc_pkg::SEL_TIME, 11'd77));
        drain();
        cfg_write(brpc_pkg::CFG_TIMEOUT, 16'd1);
        cfg_write(brpc_pkg::CFG_OBJECT, 16'hFFFF);
        cfg_close();
        send_item(word_item(1'b1, 16'hFFFF));
        send_item(point_item(2'd2, SEL_TEMP, 11'd555));
        send_item(tick_item());
        send_item(word_item(1'b0, 16'hFFFF));
        send_item(tick_item());

        items_used = 0;
        while (items_used < RANDOM_ITEMS)
        begin
            if (items_used >= 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (items_used >= RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 73;
                recv_idle_pct = 34;
            end
            squeeze = !squeezed && items_used >= 15;
            pick = $urandom_range(99);
            if (pick < 12 && !squeeze)
                reconfigure();
            else if (pick < 27 && !squeeze)
                noise_burst();
            else
            begin
                packet_run(squeeze);
                squeezed |= squeeze;
            end
            if (!squeeze && $urandom_range(3) == 0)
                drain();
        end

        // object code zero, with and without the valid flag
        drain();
        cfg_write(brpc_pkg::CFG_TIMEOUT, 16'd4);
        cfg_write(brpc_pkg::CFG_OBJECT, 16'h0000);
        cfg_close();
        send_item(word_item(1'b0, 16'h0000));
        send_item(word_item(1'b1, 16'h0000));
        send_item(random_point());
        while (sb.timer_on)
            send_item(tick_item());
        drain();

        sb.close_out();
        $display("Covered %0d accepted items, %0d reports (%0d empty), %0d results checked,",
                 sb.items_taken, sb.reports, sb.empty_reports, sb.results_checked);
        $display("short timeouts, object codes 0/0x1454/0xFFFF/random, hold-off and drains.");
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/brpc_pkg.sv
hw/rtl/beacon_reference_point_collector_top.sv
tb/tb_top.sv
